/* hw/rtl/assert_macros.svh */
// Assertion macros for RTL files that check themselves; the parser top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hw/rtl/hrlp_pkg.sv */
// Types, constants and the hex digit decoder of the hex record line parser.
package hrlp_pkg;

  localparam logic [7:0] START_CODE = 8'h3A;
  localparam logic [7:0] EOF_TYPE   = 8'h01;
  localparam logic [9:0] POS_MAX    = 10'd1023;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [8:0] BYTE_LEN     = 9'd0;
  localparam logic [8:0] BYTE_ADDR_HI = 9'd1;
  localparam logic [8:0] BYTE_ADDR_LO = 9'd2;
  localparam logic [8:0] BYTE_TYPE    = 9'd3;
  localparam logic [8:0] BYTE_DATA0   = 9'd4;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EOF     = 3'd1,
    ST_BAD_SUM = 3'd2,
    ST_FORMAT  = 3'd3,
    ST_ILLEGAL = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       line_end;
  } item_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_address;
    logic [7:0]  record_kind;
    logic [2:0]  parse_status;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } nibble_t;

  function automatic nibble_t hex_decode(logic [7:0] c);
    nibble_t r;
    r.ok  = 1'b1;
    r.val = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r.val = c[3:0];
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      r.val = c[3:0] + 4'd9;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

/* hw/rtl/hrlp_in_stage.sv */
// Input register of the hex record line parser.
module hrlp_in_stage (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [hrlp_pkg::IN_TDATA_W-1:0] s_axis_tdata_i,
  input  logic                            s_axis_tlast_i,
  input  logic                            advance_i,
  output logic                            valid_o,
  output hrlp_pkg::item_t                 item_o
);
  import hrlp_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  take;

  assign s_axis_tready_o = !valid_q || advance_i;
  assign take            = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (take) begin
      valid_d          = 1'b1;
      item_d.char_code = s_axis_tdata_i[7:0];
      item_d.line_end  = s_axis_tlast_i;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
endmodule

/* hw/rtl/hrlp_parse_core.sv */
// Line state and per-character decode of the hex record line parser.
module hrlp_parse_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  hrlp_pkg::item_t   item_i,
  output logic              res_valid_o,
  output hrlp_pkg::result_t res_o
);
  import hrlp_pkg::*;

  logic [9:0]  pos_q, pos_d;
  logic [3:0]  hi_q, hi_d;
  logic [7:0]  len_q, len_d;
  logic [15:0] addr_q, addr_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  cnt_q, cnt_d;
  logic        cks_q, cks_d;
  logic        fmt_q, fmt_d;
  logic        bad_q, bad_d;

  nibble_t     nib;
  logic [9:0]  dig;
  logic [8:0]  bidx;
  logic [7:0]  byte_val;
  logic [8:0]  data_end;
  logic        clear;

  assign nib      = hex_decode(item_i.char_code);
  assign dig      = pos_q - 10'd1;
  assign bidx     = dig[9:1];
  assign byte_val = {hi_q, nib.val};
  assign data_end = {1'b0, len_q} + BYTE_DATA0;
  assign clear    = step_i && item_i.line_end;

  always_comb begin
    pos_d       = pos_q;
    hi_d        = hi_q;
    len_d       = len_q;
    addr_d      = addr_q;
    type_d      = type_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    cks_d       = cks_q;
    fmt_d       = fmt_q;
    bad_d       = bad_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (!cks_q) begin
      if (pos_q == '0) begin
        if (item_i.char_code != START_CODE) begin
          fmt_d = 1'b1;
        end
      end else begin
        if (!nib.ok) begin
          bad_d = 1'b1;
        end
        if (!dig[0]) begin
          hi_d = nib.val;
        end else begin
          sum_d = sum_q + byte_val;
          case (bidx)
            BYTE_LEN:     len_d = byte_val;
            BYTE_ADDR_HI: addr_d = {byte_val, addr_q[7:0]};
            BYTE_ADDR_LO: addr_d = {addr_q[15:8], byte_val};
            BYTE_TYPE:    type_d = byte_val;
            default: begin
              if (bidx < data_end) begin
                if (!fmt_q && !bad_d && !item_i.line_end) begin
                  res_valid_o        = 1'b1;
                  res_o.result_kind  = KIND_DATA;
                  res_o.data_byte    = byte_val;
                  res_o.byte_address = addr_q + {8'd0, cnt_q};
                  res_o.record_kind  = type_q;
                  res_o.parse_status = ST_OK;
                end
                cnt_d = cnt_q + 8'd1;
              end else begin
                cks_d = 1'b1;
              end
            end
          endcase
        end
      end
      if (pos_q < POS_MAX) begin
        pos_d = pos_q + 10'd1;
      end
    end
    if (item_i.line_end) begin
      res_valid_o        = 1'b1;
      res_o.result_kind  = KIND_STATUS;
      res_o.data_byte    = 8'd0;
      res_o.byte_address = addr_d;
      res_o.record_kind  = type_d;
      if (fmt_d) begin
        res_o.parse_status = ST_FORMAT;
      end else if (bad_d) begin
        res_o.parse_status = ST_ILLEGAL;
      end else if (!cks_d) begin
        res_o.parse_status = ST_FORMAT;
      end else if (sum_d != 8'd0) begin
        res_o.parse_status = ST_BAD_SUM;
      end else if (type_d == EOF_TYPE) begin
        res_o.parse_status = ST_EOF;
      end else begin
        res_o.parse_status = ST_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      hi_q   <= '0;
      len_q  <= '0;
      addr_q <= '0;
      type_q <= '0;
      sum_q  <= '0;
      cnt_q  <= '0;
      cks_q  <= 1'b0;
      fmt_q  <= 1'b0;
      bad_q  <= 1'b0;
    end else if (clear) begin
      pos_q  <= '0;
      hi_q   <= '0;
      len_q  <= '0;
      addr_q <= '0;
      type_q <= '0;
      sum_q  <= '0;
      cnt_q  <= '0;
      cks_q  <= 1'b0;
      fmt_q  <= 1'b0;
      bad_q  <= 1'b0;
    end else if (step_i) begin
      pos_q  <= pos_d;
      hi_q   <= hi_d;
      len_q  <= len_d;
      addr_q <= addr_d;
      type_q <= type_d;
      sum_q  <= sum_d;
      cnt_q  <= cnt_d;
      cks_q  <= cks_d;
      fmt_q  <= fmt_d;
      bad_q  <= bad_d;
    end
  end
endmodule

/* hw/rtl/hrlp_out_stage.sv */
// Result register of the hex record line parser.
module hrlp_out_stage (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             load_i,
  input  hrlp_pkg::result_t                res_i,
  output logic                             space_o,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [hrlp_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic                             m_axis_tuser_o
);
  import hrlp_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q, res_d;

  assign space_o = !valid_q || m_axis_tready_i;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (load_i) begin
      valid_d = 1'b1;
      res_d   = res_i;
    end else if (m_axis_tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tuser_o  = res_q.result_kind;
  assign m_axis_tdata_o  = {5'd0, res_q.parse_status, res_q.record_kind,
                            res_q.byte_address, res_q.data_byte};
endmodule

/* hw/rtl/hex_record_line_parser.sv */
// Top level of the hex record line parser.
// Input stream: one ASCII character per request in s_axis_tdata_i, with
// s_axis_tlast_i high on the last character of a record line.
// Output stream: one result per request. m_axis_tuser_o is the result kind
// (0 data byte, 1 end-of-line status). Data results come out as each data
// byte completes without a fault; one status result ends each line.
// A character taken goes into the input register, and its result into the
// result register. Throughput: one character per cycle while the receiver
// takes results, set by the single decode-and-update pass through the line
// state between the input register and the result register.
// Reset clears the line state and both valid flags; the next character starts
// a new line. When the receiver stalls, the result register holds, the input
// register fills, and s_axis_tready_o drops until the result is taken.
`include "assert_macros.svh"

module hex_record_line_parser (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // [7:0] char_code
  input  logic [hrlp_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  logic                             s_axis_tlast_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [7:0] data_byte, [23:8] byte_address, [31:24] record_kind,
  // [34:32] parse_status, [39:35] zero
  output logic [hrlp_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  // [0] result_kind
  output logic                             m_axis_tuser_o
);
  import hrlp_pkg::*;

  logic    in_valid;
  item_t   item;
  logic    out_space;
  logic    step;
  logic    res_valid;
  result_t res;

  assign step = in_valid && out_space;

  hrlp_in_stage u_in_stage (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .advance_i       (step),
    .valid_o         (in_valid),
    .item_o          (item)
  );

  hrlp_parse_core u_parse_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  hrlp_out_stage u_out_stage (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (step && res_valid),
    .res_i           (res),
    .space_o         (out_space),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  `ASSERT_ALWAYS(a_step_has_space, clk_i, rst_ni,
    !step || !m_axis_tvalid_o || m_axis_tready_i)
  `ASSERT_ALWAYS(a_full_stall_blocks, clk_i, rst_ni,
    !(in_valid && m_axis_tvalid_o && !m_axis_tready_i) || !s_axis_tready_o)
  `ASSERT_ALWAYS(a_status_no_data, clk_i, rst_ni,
    !(m_axis_tvalid_o && m_axis_tuser_o == KIND_STATUS) || m_axis_tdata_o[7:0] == 8'd0)
  `ASSERT_NEXT(a_data_status_ok, clk_i, rst_ni,
    step && res_valid && res.result_kind == KIND_DATA,
    m_axis_tvalid_o && m_axis_tdata_o[34:32] == ST_OK)
endmodule
